// File: hdl/jrsp_pkg.sv
package jrsp_pkg;

  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PosW = 16;
  localparam int unsigned MagW = 15;

  localparam logic [MagW-1:0] FullScale = 15'd32767;

  localparam logic            RstAxisSelect = 1'b0;
  localparam logic [MagW-1:0] RstDeadZone = 15'd1638;
  localparam logic [MagW-1:0] RstChangeLimit = 15'd6554;
  localparam logic [15:0]     RstMinInterval = 16'd10;
  localparam logic [15:0]     RstMaxInterval = 16'd500;
  localparam logic [PosW-1:0] RstStepsPerRev = 16'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAxisSelect  = 3'd0,
    CfgDeadZone    = 3'd1,
    CfgChangeLimit = 3'd2,
    CfgMinInterval = 3'd3,
    CfgMaxInterval = 3'd4,
    CfgStepsPerRev = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic            start;
    logic [PosW-1:0] dividend;
    logic [PosW:0]   modulus;
  } mod_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [PosW-1:0] rem;
  } mod_rsp_t;

endpackage

// File: hdl/jrsp_posmod.sv
module jrsp_posmod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jrsp_pkg::mod_req_t  req_i,
  output jrsp_pkg::mod_rsp_t  rsp_o
);

  localparam int unsigned W = jrsp_pkg::PosW;
  localparam int unsigned CntW = $clog2(W);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    num_q, num_d;
  logic [W:0]      mod_q, mod_d;
  logic [W:0]      rem_q, rem_d;
  logic [W:0]      shifted;
  logic            last;

  // one quotient bit per cycle, restoring remainder
  always_comb begin
    shifted = {rem_q[W-1:0], num_q[W-1]};
    last    = busy_q && (cnt_q == '0);
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    mod_d   = mod_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W - 1);
      num_d  = req_i.dividend;
      mod_d  = req_i.modulus;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[W-2:0], 1'b0};
      rem_d = (shifted >= mod_q) ? shifted - mod_q : shifted;
      cnt_d = cnt_q - 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    mod_q <= mod_d;
    rem_q <= rem_d;
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last && !req_i.start;
    end
  end

  // hold off the user through the load cycle as well
  assign rsp_o.busy = busy_q || done_q || req_i.start;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[W-1:0];

endmodule

// File: hdl/joystick_rate_stepper_pulser_top.sv
// Step/direction pulse generator driven by one joystick axis. Each input word is one timer
// tick carrying both axes plus connect and stop flags; each tick yields exactly one output
// word with step pulse, direction-change strobe, direction and wrapped position. The block
// takes one word per clock while neither the output stalls nor a remainder pass runs: a tick
// sits in the input register and its result is loaded into the output register, and a
// stalled output only holds the pipe. The wait interval is multiplied out in the step cycle
// and divided by full scale on the following cycle. A write to steps_per_rev starts a
// remainder pass, followed by a load of its result, that reduces a copy of the held position
// into the new range for the next step; input is stalled until that result is loaded.
module joystick_rate_stepper_pulser_top #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [VALUE_BITS-1:0]       x_value_i,
  input  logic signed [VALUE_BITS-1:0]       y_value_i,
  input  logic                               joy_connected_i,
  input  logic                               stop_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               step_pulse_o,
  output logic                               dir_strobe_o,
  output logic                               step_dir_o,
  output logic [jrsp_pkg::PosW-1:0]          position_o,
  input  logic                               cfg_we_i,
  input  logic [jrsp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [jrsp_pkg::CfgW-1:0]          cfg_data_i
);

  localparam int unsigned PW = jrsp_pkg::PosW;
  localparam int unsigned MW = jrsp_pkg::MagW;

  // configuration
  logic          axis_q;
  logic [MW-1:0] dz_q, cl_q;
  logic [15:0]   min_q, max_q;
  logic [PW-1:0] spr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= jrsp_pkg::RstAxisSelect;
      dz_q   <= jrsp_pkg::RstDeadZone;
      cl_q   <= jrsp_pkg::RstChangeLimit;
      min_q  <= jrsp_pkg::RstMinInterval;
      max_q  <= jrsp_pkg::RstMaxInterval;
      spr_q  <= jrsp_pkg::RstStepsPerRev;
    end else if (cfg_we_i) begin
      unique case (jrsp_pkg::cfg_idx_e'(cfg_idx_i))
        jrsp_pkg::CfgAxisSelect:  axis_q <= cfg_data_i[0];
        jrsp_pkg::CfgDeadZone:    dz_q   <= cfg_data_i[MW-1:0];
        jrsp_pkg::CfgChangeLimit: cl_q   <= cfg_data_i[MW-1:0];
        jrsp_pkg::CfgMinInterval: min_q  <= cfg_data_i;
        jrsp_pkg::CfgMaxInterval: max_q  <= cfg_data_i;
        jrsp_pkg::CfgStepsPerRev: spr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position remainder unit
  jrsp_pkg::mod_req_t mod_req;
  jrsp_pkg::mod_rsp_t mod_rsp;
  logic [PW-1:0]      pos_q, red_q;

  assign mod_req.start    = cfg_we_i &&
                            (jrsp_pkg::cfg_idx_e'(cfg_idx_i) == jrsp_pkg::CfgStepsPerRev);
  assign mod_req.dividend = pos_q;
  assign mod_req.modulus  = (cfg_data_i == '0) ? {1'b1, {PW{1'b0}}} : {1'b0, cfg_data_i};

  jrsp_posmod u_posmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // input register
  logic                         in_vld_q;
  logic signed [VALUE_BITS-1:0] x_q, y_q;
  logic                         conn_q, stop_q;
  logic                         out_vld_q;
  logic                         adv;

  assign adv        = in_vld_q && !mod_rsp.busy && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      x_q    <= x_value_i;
      y_q    <= y_value_i;
      conn_q <= joy_connected_i;
      stop_q <= stop_i;
    end
  end

  // state
  logic          waiting_q, fresh_q, dir_q;
  logic [15:0]   ticks_q, lo_q;
  logic [MW-1:0] ref_q;
  logic [30:0]   prod_abs_q;
  logic          prod_neg_q;

  // magnitude of the selected axis
  logic signed [VALUE_BITS-1:0] raw;
  logic                         neg;
  logic [VALUE_BITS-1:0]        absu;
  logic [MW-1:0]                mag;

  always_comb begin
    raw  = axis_q ? y_q : x_q;
    neg  = raw[VALUE_BITS-1];
    absu = neg ? VALUE_BITS'(-raw) : VALUE_BITS'(raw);
    mag  = (32'(absu) > 32'(jrsp_pkg::FullScale)) ? jrsp_pkg::FullScale : MW'(absu);
  end

  // interval = lo + prod / FullScale, using 2^15 - 1 folding
  logic [15:0] q_a;
  logic [14:0] q_b;
  logic [16:0] q_s, q_sum;
  logic [15:0] q_cd, quo;
  logic [17:0] lo_ext, iv_full;
  logic [15:0] iv;

  always_comb begin
    q_a     = prod_abs_q[30:15];
    q_b     = prod_abs_q[14:0];
    q_s     = {1'b0, q_a} + {2'b0, q_b};
    q_cd    = {1'b0, q_s[14:0]} + {14'b0, q_s[16:15]};
    q_sum   = {1'b0, q_a} + {15'b0, q_s[16:15]}
            + {16'b0, (q_cd >= 16'(jrsp_pkg::FullScale))};
    quo     = q_sum[15:0];
    lo_ext  = {2'b0, lo_q};
    iv_full = prod_neg_q ? lo_ext - {2'b0, quo} : lo_ext + {2'b0, quo};
    iv      = iv_full[15:0];
  end

  // product for the next interval
  logic signed [16:0] span;
  logic [MW-1:0]      om;
  logic signed [32:0] prod;
  logic [30:0]        prod_abs;

  always_comb begin
    span     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
    om       = jrsp_pkg::FullScale - mag;
    prod     = span * $signed({1'b0, om});
    prod_abs = prod[32] ? 31'(-prod) : 31'(prod);
  end

  // decision
  logic          force_idle, wt0, still, step, new_dir, strobe;
  logic [15:0]   tk0, tk1;
  logic [MW-1:0] diff;
  logic [PW:0]   modulus, inc;
  logic [PW-1:0] new_pos;

  always_comb begin
    force_idle = stop_q || !conn_q;
    wt0        = fresh_q ? (iv != '0) : waiting_q;
    tk0        = fresh_q ? iv : ticks_q;
    tk1        = tk0 - 1'b1;
    diff       = (mag > ref_q) ? mag - ref_q : ref_q - mag;
    still      = wt0 && (diff <= cl_q) && (tk1 != '0);
    step       = !force_idle && !still && (mag >= dz_q);
    new_dir    = neg;
    strobe     = new_dir != dir_q;
    modulus    = (spr_q == '0) ? {1'b1, {PW{1'b0}}} : {1'b0, spr_q};
    inc        = {1'b0, red_q} + 1'b1;
    if (!new_dir) begin
      new_pos = (inc == modulus) ? '0 : inc[PW-1:0];
    end else begin
      new_pos = (red_q == '0) ? PW'(modulus - 1'b1) : red_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      fresh_q   <= 1'b0;
      ticks_q   <= '0;
      ref_q     <= '0;
      dir_q     <= 1'b0;
      pos_q     <= '0;
      red_q     <= '0;
    end else begin
      if (adv) begin
        if (force_idle) begin
          waiting_q <= 1'b0;
          fresh_q   <= 1'b0;
          ticks_q   <= '0;
        end else if (still) begin
          waiting_q <= 1'b1;
          fresh_q   <= 1'b0;
          ticks_q   <= tk1;
        end else if (step) begin
          waiting_q <= 1'b0;
          fresh_q   <= 1'b1;
          ref_q     <= mag;
          dir_q     <= new_dir;
          pos_q     <= new_pos;
          red_q     <= new_pos;
        end else begin
          waiting_q <= 1'b0;
          fresh_q   <= 1'b0;
        end
      end else if (fresh_q) begin
        waiting_q <= iv != '0;
        ticks_q   <= iv;
        fresh_q   <= 1'b0;
      end
      if (mod_rsp.done) begin
        red_q <= mod_rsp.rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && step) begin
      prod_abs_q <= prod_abs;
      prod_neg_q <= prod[32];
      lo_q       <= min_q;
    end
  end

  // result register
  logic          pulse_q, strobe_q, odir_q;
  logic [PW-1:0] opos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pulse_q  <= step;
      strobe_q <= step && strobe;
      odir_q   <= step ? new_dir : dir_q;
      opos_q   <= step ? new_pos : pos_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign step_pulse_o = pulse_q;
  assign dir_strobe_o = strobe_q;
  assign step_dir_o   = odir_q;
  assign position_o   = opos_q;

endmodule

// File: hdl/jrsp_checker.sv
module jrsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          step_pulse_o,
  input logic                          dir_strobe_o,
  input logic                          step_dir_o,
  input logic [jrsp_pkg::PosW-1:0]     position_o
);

  logic out_take;

  assign out_take = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o)
      && $stable(step_pulse_o) && $stable(step_dir_o) && $stable(dir_strobe_o))
    else $error("stalled output word changed");

  a_strobe_needs_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dir_strobe_o |-> step_pulse_o)
    else $error("direction strobe without step pulse");

  a_no_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && $past(out_take) && !step_pulse_o |->
      position_o == $past(position_o) && step_dir_o == $past(step_dir_o))
    else $error("position or direction moved without a step");

  a_strobe_flips_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && $past(out_take) && step_pulse_o |->
      dir_strobe_o == (step_dir_o != $past(step_dir_o)))
    else $error("direction strobe disagrees with direction change");

endmodule

bind joystick_rate_stepper_pulser_top jrsp_checker u_jrsp_checker (.*);
